FILE: hw/rtl/fnda_pkg.sv
// Shared constants, register codes and arithmetic helpers for the noise displacement block.
package fnda_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int OCT_W      = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMOUNT  = 3'd0,
		REG_SCALE   = 3'd1,
		REG_OCTAVES = 3'd2,
		REG_OFFSET  = 3'd3,
		REG_WIDTH   = 3'd4,
		REG_HEIGHT  = 3'd5
	} cfg_reg_t;

	localparam logic signed [15:0] RST_AMOUNT  = 16'sd3200;
	localparam logic [16:0]        RST_SCALE   = 17'd1311;
	localparam logic [3:0]         RST_OCTAVES = 4'd3;
	localparam logic [31:0]        RST_OFFSET  = 32'd0;
	localparam logic [12:0]        RST_WIDTH   = 13'd1920;
	localparam logic [12:0]        RST_HEIGHT  = 13'd1080;

	localparam logic [31:0] HASH_A = 32'd374761393;
	localparam logic [31:0] HASH_B = 32'd668265263;
	localparam logic [31:0] HASH_C = 32'd1274126177;

	// second axis samples the noise 100 lattice units further on
	localparam logic [31:0] AXIS_SHIFT = 32'd6553600;

	// lerp in Q0.16: p + floor((q - p) * t / 2^16)
	function automatic logic [15:0] blend(input logic [15:0] p, input logic [15:0] q,
			input logic [15:0] t);
		logic signed [16:0] dq;
		logic signed [34:0] m;
		logic signed [17:0] r;
		dq = $signed({1'b0, q}) - $signed({1'b0, p});
		m = dq * $signed({1'b0, t});
		r = $signed({2'b0, p}) + 18'(m >>> 16);
		blend = r[15:0];
	endfunction

	// floor(2^32 / (2^n - 1)), one octave capped to fit 32 bits
	function automatic logic [31:0] recip(input logic [OCT_W-1:0] n);
		case (n)
			5'd1:    recip = 32'hFFFFFFFF;
			5'd2:    recip = 32'h55555555;
			5'd3:    recip = 32'h24924924;
			5'd4:    recip = 32'h11111111;
			5'd5:    recip = 32'h08421084;
			5'd6:    recip = 32'h04104104;
			5'd7:    recip = 32'h02040810;
			5'd8:    recip = 32'h01010101;
			5'd9:    recip = 32'h00804020;
			5'd10:   recip = 32'h00401004;
			5'd11:   recip = 32'h00200400;
			5'd12:   recip = 32'h00100100;
			5'd13:   recip = 32'h00080040;
			5'd14:   recip = 32'h00040010;
			5'd15:   recip = 32'h00020004;
			5'd16:   recip = 32'h00010001;
			default: recip = 32'hFFFFFFFF;
		endcase
	endfunction

endpackage

FILE: hw/rtl/fnda_octave.sv
// One octave of value noise: lattice hash of four corners, smoothstep and bilinear blend.
module fnda_octave #(
	parameter int CW  = 34,
	parameter int OCT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [CW-1:0] cx,
	input  logic [CW-1:0] cy,
	output logic [15:0]   noise
);
	import fnda_pkg::*;

	localparam int SW = CW + 32;

	logic [SW-1:0] csx, csy;
	logic [31:0]   ix, iy;
	logic [15:0]   fx, fy;

	assign csx = {32'b0, cx} << OCT;
	assign csy = {32'b0, cy} << OCT;
	assign ix  = csx[47:16];
	assign iy  = csy[47:16];
	assign fx  = csx[15:0];
	assign fy  = csy[15:0];

	logic [31:0] xa_s1, yb_s1, fxx_s1, fyy_s1;
	logic [15:0] fx_s1, fy_s1;

	logic [31:0] g_s2 [4];
	logic [15:0] tx_s2, ty_s2;
	logic [31:0] h1_s3 [4];
	logic [15:0] tx_s3, ty_s3;
	logic [15:0] v_s4 [4];
	logic [15:0] tx_s4, ty_s4;
	logic [15:0] a_s5, b_s5, ty_s5;
	logic [15:0] n_s6;

	logic [31:0] h0 [4];
	logic [31:0] gc [4];
	logic [49:0] smx, smy;

	always_comb begin
		h0[0] = xa_s1 + yb_s1;
		h0[1] = xa_s1 + HASH_A + yb_s1;
		h0[2] = xa_s1 + yb_s1 + HASH_B;
		h0[3] = xa_s1 + HASH_A + yb_s1 + HASH_B;
		for (int k = 0; k < 4; k++) begin
			gc[k] = h0[k] ^ 32'($signed(h0[k]) >>> 13);
		end
		smx = 50'(fxx_s1) * 50'(18'd196608 - {1'b0, fx_s1, 1'b0});
		smy = 50'(fyy_s1) * 50'(18'd196608 - {1'b0, fy_s1, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s1  <= ix * HASH_A;
			yb_s1  <= iy * HASH_B;
			fxx_s1 <= 32'(fx) * 32'(fx);
			fyy_s1 <= 32'(fy) * 32'(fy);
			fx_s1  <= fx;
			fy_s1  <= fy;

			// bits 30:15 of the arithmetic shift by 16 are all copies of the sign bit
			for (int k = 0; k < 4; k++) begin
				g_s2[k]  <= gc[k];
				h1_s3[k] <= g_s2[k] * HASH_C;
				v_s4[k]  <= h1_s3[k][30:15] ^ {16{h1_s3[k][31]}};
			end
			tx_s2 <= smx[47:32];
			ty_s2 <= smy[47:32];
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;

			a_s5  <= blend(v_s4[0], v_s4[1], tx_s4);
			b_s5  <= blend(v_s4[2], v_s4[3], tx_s4);
			ty_s5 <= ty_s4;

			n_s6 <= blend(a_s5, b_s5, ty_s5);
		end
	end

	assign noise = n_s6;

endmodule

FILE: hw/rtl/fnda_norm.sv
// Weighted octave sum and normalisation by the weight total through a reciprocal multiply.
module fnda_norm #(
	parameter int MAX_OCTAVES = 10
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [MAX_OCTAVES-1:0][15:0] octave_noise,
	input  logic [3:0]                  octave_count,
	output logic [15:0]                 noise
);
	import fnda_pkg::*;

	localparam int SWN = 16 + MAX_OCTAVES;

	logic [OCT_W-1:0] n_eff;
	logic [SWN-1:0]   sum_c;
	logic [SWN-1:0]   sum_s1;
	logic [SWN-1:0]   shd;
	logic [31:0]      tq;
	logic [63:0]      prod;
	logic [15:0]      q0_s2;
	logic [31:0]      t_s2;
	logic [32:0]      qd, rem;
	logic [32:0]      dv;
	logic [15:0]      n_s3;

	always_comb begin
		if (octave_count == 4'd0) begin
			n_eff = OCT_W'(1);
		end else if (OCT_W'(octave_count) > OCT_W'(MAX_OCTAVES)) begin
			n_eff = OCT_W'(MAX_OCTAVES);
		end else begin
			n_eff = OCT_W'(octave_count);
		end

		sum_c = '0;
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			if (OCT_W'(i) < n_eff) begin
				sum_c = sum_c + (SWN'(octave_noise[i]) << (MAX_OCTAVES - 1 - i));
			end
		end

		// weights total 2^(M-n) * (2^n - 1): shift off the power of two first
		shd  = sum_s1 >> (OCT_W'(MAX_OCTAVES) - n_eff);
		tq   = 32'(shd);
		prod = 64'(tq) * 64'(recip(n_eff));

		dv  = (33'd1 << n_eff) - 33'd1;
		qd  = (33'(q0_s2) << n_eff) - 33'(q0_s2);
		rem = 33'(t_s2) - qd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_c;
			q0_s2  <= prod[47:32];
			t_s2   <= tq;
			n_s3   <= (rem >= dv) ? q0_s2 + 16'd1 : q0_s2;
		end
	end

	assign noise = n_s3;

endmodule

FILE: hw/rtl/fnda_place.sv
// Displacement gain, truncation toward zero and frame clamp; holds the output register.
module fnda_place #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [COORD_BITS-1:0] pixel,
	input  logic [15:0]           noise,
	input  logic signed [15:0]    amount,
	input  logic [12:0]           frame,
	output logic [COORD_BITS-1:0] source
);
	localparam int PW = COORD_BITS + 25;
	localparam logic [16:0] FMAX = 17'(2 ** COORD_BITS);

	logic signed [16:0]    nc;
	logic signed [32:0]    d_s1;
	logic [COORD_BITS-1:0] px_s1;
	logic signed [PW-1:0]  pos;
	logic [COORD_BITS+1:0] whole;
	logic [16:0]           fr;
	logic [COORD_BITS-1:0] lim;
	logic [COORD_BITS-1:0] res;
	logic [COORD_BITS-1:0] src_s2;

	assign nc = $signed({1'b0, noise}) - 17'sd32768;

	always_comb begin
		pos   = $signed({3'b0, px_s1, 22'b0}) + PW'(d_s1);
		whole = pos[COORD_BITS+23:22];
		fr    = 17'(frame);
		if (frame == 13'd0) begin
			lim = '0;
		end else if (fr > FMAX) begin
			lim = COORD_BITS'(FMAX - 17'd1);
		end else begin
			lim = COORD_BITS'(fr - 17'd1);
		end
		if (pos[PW-1]) begin
			res = '0;
		end else if (whole > (COORD_BITS+2)'(lim)) begin
			res = lim;
		end else begin
			res = whole[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= nc * amount;
			px_s1  <= pixel;
			src_s2 <= res;
		end
	end

	assign source = src_s2;

endmodule

FILE: hw/rtl/fractal_noise_displace_address_top.sv
// Top level of the fractal value-noise displacement address generator.
// Takes one destination pixel (pixel_x, pixel_y) per item on the input channel and
// gives the source pixel (source_x, source_y) to fetch on the output channel.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Stages from input accept to output valid: coordinate multiply (1), axis offset (1),
// octave hash/smoothstep/blend lanes (6), weighted sum and reciprocal normalisation (3),
// gain and clamp (2, the last is the output register).
// Throughput is one item per clock unless the output stalls; every octave of both axes has its own lane.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; bubbles in flight are not squeezed out.
// Reset clears the valid bits and loads the register defaults. Registers are
// written through cfg_we/cfg_index/cfg_data and must only change while idle.
module fractal_noise_displace_address_top #(
	parameter int COORD_BITS  = 12,
	parameter int MAX_OCTAVES = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fnda_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fnda_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [COORD_BITS-1:0]           pixel_x,
	input  logic [COORD_BITS-1:0]           pixel_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [COORD_BITS-1:0]           source_x,
	output logic [COORD_BITS-1:0]           source_y
);
	import fnda_pkg::*;

	// pixel * scale + offset needs one carry bit, the axis shift another
	localparam int CW     = ((COORD_BITS + 17 > 32) ? COORD_BITS + 17 : 32) + 2;
	localparam int NSTAGE = 13;
	localparam int PXLAT  = 11;

	logic signed [15:0] amount_q;
	logic [16:0]        scale_q;
	logic [3:0]         octaves_q;
	logic [31:0]        offset_q;
	logic [12:0]        width_q;
	logic [12:0]        height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q  <= RST_AMOUNT;
			scale_q   <= RST_SCALE;
			octaves_q <= RST_OCTAVES;
			offset_q  <= RST_OFFSET;
			width_q   <= RST_WIDTH;
			height_q  <= RST_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_AMOUNT:  amount_q  <= $signed(cfg_data[15:0]);
				REG_SCALE:   scale_q   <= cfg_data[16:0];
				REG_OCTAVES: octaves_q <= cfg_data[3:0];
				REG_OFFSET:  offset_q  <= cfg_data;
				REG_WIDTH:   width_q   <= cfg_data[12:0];
				REG_HEIGHT:  height_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic vld_s [1:NSTAGE];
	logic [COORD_BITS-1:0] pxx_s [1:PXLAT];
	logic [COORD_BITS-1:0] pxy_s [1:PXLAT];

	assign en       = ~vld_s[NSTAGE] | ~out_stall;
	assign in_stall = ~en;
	assign out_valid = vld_s[NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTAGE; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NSTAGE; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	logic [CW-1:0] cx_s1, cy_s1;
	logic [CW-1:0] ax_s2, ay_s2, bx_s2, by_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= CW'(pixel_x) * CW'(scale_q) + CW'(offset_q);
			cy_s1 <= CW'(pixel_y) * CW'(scale_q) + CW'(offset_q);
			ax_s2 <= cx_s1;
			ay_s2 <= cy_s1;
			bx_s2 <= cx_s1 + CW'(AXIS_SHIFT);
			by_s2 <= cy_s1 + CW'(AXIS_SHIFT);
			pxx_s[1] <= pixel_x;
			pxy_s[1] <= pixel_y;
			for (int k = 2; k <= PXLAT; k++) begin
				pxx_s[k] <= pxx_s[k-1];
				pxy_s[k] <= pxy_s[k-1];
			end
		end
	end

	logic [MAX_OCTAVES-1:0][15:0] oct_x, oct_y;
	logic [15:0] noise_x, noise_y;

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		fnda_octave #(.CW(CW), .OCT(i)) u_oct_x (
			.clk   (clk),
			.en    (en),
			.cx    (ax_s2),
			.cy    (ay_s2),
			.noise (oct_x[i])
		);
		fnda_octave #(.CW(CW), .OCT(i)) u_oct_y (
			.clk   (clk),
			.en    (en),
			.cx    (bx_s2),
			.cy    (by_s2),
			.noise (oct_y[i])
		);
	end

	fnda_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm_x (
		.clk          (clk),
		.en           (en),
		.octave_noise (oct_x),
		.octave_count (octaves_q),
		.noise        (noise_x)
	);

	fnda_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm_y (
		.clk          (clk),
		.en           (en),
		.octave_noise (oct_y),
		.octave_count (octaves_q),
		.noise        (noise_y)
	);

	fnda_place #(.COORD_BITS(COORD_BITS)) u_place_x (
		.clk    (clk),
		.en     (en),
		.pixel  (pxx_s[PXLAT]),
		.noise  (noise_x),
		.amount (amount_q),
		.frame  (width_q),
		.source (source_x)
	);

	fnda_place #(.COORD_BITS(COORD_BITS)) u_place_y (
		.clk    (clk),
		.en     (en),
		.pixel  (pxy_s[PXLAT]),
		.noise  (noise_y),
		.amount (amount_q),
		.frame  (height_q),
		.source (source_y)
	);

endmodule
